### src/frc_pkg.sv
package frc_pkg;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned FREQ_W  = 22;
  localparam int unsigned RATE_W  = 24;
  localparam int unsigned THR_W   = 10;
  localparam int unsigned FRAC_W  = 8;

  // Divider datapath: the scaled sample rate fits in 24 bits for any rate up to 65535 Hz
  localparam int unsigned DIVQ_W  = 24;
  localparam int unsigned DIVD_W  = FREQ_W + 1;
  localparam int unsigned ITER_W  = 5;
  localparam int unsigned PROD_W  = 2 * FREQ_W;

  localparam int unsigned SAMPLE_RATE_HZ = 16000;

  localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;
  localparam logic [RATE_W-1:0] RATE_MAX   = '1;
  localparam logic [FREQ_W-1:0] RESET_FREQ = FREQ_W'(10240);

  localparam logic [THR_W-1:0] FREQ_THR_RESET = THR_W'(50);
  localparam logic [THR_W-1:0] RATE_THR_RESET = THR_W'(10);

  // APB register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_FREQ_THR = 1'b0;
  localparam logic REG_RATE_THR = 1'b1;

endpackage

### src/frc_in_if.sv
interface frc_in_if;
  logic                           valid;
  logic                           ready;
  logic [frc_pkg::COUNT_W-1:0]    period_count;

  modport source (output valid, output period_count, input ready);
  modport sink   (input valid, input period_count, output ready);
endinterface

### src/frc_out_if.sv
interface frc_out_if;
  logic                          valid;
  logic                          ready;
  logic [frc_pkg::FREQ_W-1:0]    frequency;
  logic [frc_pkg::RATE_W-1:0]    rate_of_change;
  logic                          unstable_now;
  logic                          unstable_before;

  modport source (output valid, output frequency, output rate_of_change,
                  output unstable_now, output unstable_before, input ready);
  modport sink   (input valid, input frequency, input rate_of_change,
                  input unstable_now, input unstable_before, output ready);
endinterface

### src/frequency_rocof_stability_check_unit.sv
// Under-frequency and rate-of-change-of-frequency check.
// in_i carries one period count (samples between crossings); out_o returns one
// result per transaction: frequency and |rate of change| in 1/256 Hz units, the
// instability flag for this item and the flag of the item before.
// Thresholds (whole Hz and Hz/s) are written over the APB port: freq threshold
// at address 0, rate threshold at address 4; write them only while idle.
// One item is worked through a single shared restoring divider and a single
// 22x22 multiplier under a small sequencer: the accepting edge loads the
// divider, then 24 divide steps for the frequency, a saturate, a multiply, a
// load, 22 divide steps for the harmonic term, a multiply and a compare, after
// which out_o.valid rises and the result can be taken. When the count is zero
// the frequency divide and saturate are skipped.
// in_i.ready is high only while no item is in flight; the next transaction is
// taken the cycle after the result is taken, not before.
// If the receiver stalls, the result holds in the output register and no new
// item is taken. Reset restores the thresholds to 50 Hz and 10 Hz/s, the
// previous frequency to 40 Hz and the previous flag to stable, and drops any
// item in flight.
module frequency_rocof_stability_check_unit #(
  parameter int unsigned SAMPLE_RATE_HZ = frc_pkg::SAMPLE_RATE_HZ
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  frc_in_if.sink                        in_i,
  frc_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [frc_pkg::PADDR_W-1:0]   paddr,
  input  logic [frc_pkg::PDATA_W-1:0]   pwdata,
  output logic [frc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam logic [frc_pkg::DIVQ_W-1:0] SCALED_RATE =
    frc_pkg::DIVQ_W'(SAMPLE_RATE_HZ * (2 ** frc_pkg::FRAC_W));

  typedef enum logic [2:0] {
    ST_IDLE, ST_FDIV, ST_FSAT, ST_FMUL, ST_TLOAD, ST_TDIV, ST_RMUL, ST_OUT
  } state_e;

  state_e                           state_q, state_d;
  logic [frc_pkg::THR_W-1:0]        freq_thr_q, freq_thr_d;
  logic [frc_pkg::THR_W-1:0]        rate_thr_q, rate_thr_d;
  logic [frc_pkg::FREQ_W-1:0]       prev_freq_q, prev_freq_d;
  logic                             prev_unst_q, prev_unst_d;
  logic [frc_pkg::FREQ_W-1:0]       freq_q, freq_d;
  logic [frc_pkg::FREQ_W-1:0]       diff_q, diff_d;
  logic [frc_pkg::DIVD_W-1:0]       sum_q, sum_d;
  logic [frc_pkg::DIVD_W-1:0]       div_q, div_d;
  logic [frc_pkg::DIVQ_W-1:0]       rem_q, rem_d;
  logic [frc_pkg::DIVQ_W-1:0]       quo_q, quo_d;
  logic [frc_pkg::ITER_W-1:0]       iter_q, iter_d;
  logic [frc_pkg::PROD_W-1:0]       prod_q, prod_d;
  logic                             out_valid_q, out_valid_d;
  logic [frc_pkg::FREQ_W-1:0]       out_freq_q, out_freq_d;
  logic [frc_pkg::RATE_W-1:0]       out_rate_q, out_rate_d;
  logic                             out_now_q, out_now_d;
  logic                             out_before_q, out_before_d;

  logic                             cfg_wr;
  logic [frc_pkg::FREQ_W-1:0]       mul_a, mul_b;
  logic [frc_pkg::PROD_W-1:0]       mul_p;
  logic [frc_pkg::DIVQ_W-1:0]       rem_sh, rem_sub;
  logic                             take;
  logic [frc_pkg::PROD_W:0]         num;
  logic [frc_pkg::PROD_W-frc_pkg::FRAC_W-1:0] rate_raw;
  logic [frc_pkg::RATE_W-1:0]       rate_sat;
  logic                             now;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == frc_pkg::REG_RATE_THR)
                  ? frc_pkg::PDATA_W'(rate_thr_q) : frc_pkg::PDATA_W'(freq_thr_q);

  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.frequency       = out_freq_q;
  assign out_o.rate_of_change  = out_rate_q;
  assign out_o.unstable_now    = out_now_q;
  assign out_o.unstable_before = out_before_q;

  // Shared multiplier: f * prev first, then |f - prev| * harmonic term
  assign mul_a = (state_q == ST_FMUL) ? freq_q : diff_q;
  assign mul_b = (state_q == ST_FMUL) ? prev_freq_q : quo_q[frc_pkg::FREQ_W-1:0];
  assign mul_p = mul_a * mul_b;

  // Shared restoring divider step
  assign rem_sh  = {rem_q[frc_pkg::DIVQ_W-2:0], quo_q[frc_pkg::DIVQ_W-1]};
  assign take    = (rem_sh >= frc_pkg::DIVQ_W'(div_q));
  assign rem_sub = rem_sh - frc_pkg::DIVQ_W'(div_q);

  assign num      = {prod_q, 1'b0};
  assign rate_raw = prod_q[frc_pkg::PROD_W-1:frc_pkg::FRAC_W];
  assign rate_sat = (rate_raw[frc_pkg::PROD_W-frc_pkg::FRAC_W-1:frc_pkg::RATE_W] != '0)
                    ? frc_pkg::RATE_MAX : rate_raw[frc_pkg::RATE_W-1:0];
  assign now = (freq_q < frc_pkg::FREQ_W'({freq_thr_q, frc_pkg::FRAC_W'(0)}))
            || (rate_sat > frc_pkg::RATE_W'({rate_thr_q, frc_pkg::FRAC_W'(0)}));

  always_comb begin
    state_d      = state_q;
    freq_thr_d   = freq_thr_q;
    rate_thr_d   = rate_thr_q;
    prev_freq_d  = prev_freq_q;
    prev_unst_d  = prev_unst_q;
    freq_d       = freq_q;
    diff_d       = diff_q;
    sum_d        = sum_q;
    div_d        = div_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    iter_d       = iter_q;
    prod_d       = prod_q;
    out_valid_d  = out_valid_q;
    out_freq_d   = out_freq_q;
    out_rate_d   = out_rate_q;
    out_now_d    = out_now_q;
    out_before_d = out_before_q;

    if (cfg_wr) begin
      if (paddr[2] == frc_pkg::REG_FREQ_THR) begin
        freq_thr_d = pwdata[frc_pkg::THR_W-1:0];
      end else begin
        rate_thr_d = pwdata[frc_pkg::THR_W-1:0];
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          rem_d  = '0;
          quo_d  = SCALED_RATE;
          div_d  = frc_pkg::DIVD_W'(in_i.period_count);
          iter_d = frc_pkg::ITER_W'(frc_pkg::DIVQ_W);
          if (in_i.period_count == '0) begin
            freq_d  = frc_pkg::FREQ_MAX;
            state_d = ST_FMUL;
          end else begin
            state_d = ST_FDIV;
          end
        end
      end
      ST_FDIV, ST_TDIV: begin
        rem_d  = take ? rem_sub : rem_sh;
        quo_d  = {quo_q[frc_pkg::DIVQ_W-2:0], take};
        iter_d = iter_q - 1'b1;
        if (iter_q == frc_pkg::ITER_W'(1)) begin
          state_d = (state_q == ST_FDIV) ? ST_FSAT : ST_RMUL;
        end
      end
      ST_FSAT: begin
        freq_d  = (quo_q[frc_pkg::DIVQ_W-1:frc_pkg::FREQ_W] != '0)
                  ? frc_pkg::FREQ_MAX : quo_q[frc_pkg::FREQ_W-1:0];
        state_d = ST_FMUL;
      end
      ST_FMUL: begin
        prod_d  = mul_p;
        sum_d   = frc_pkg::DIVD_W'(freq_q) + frc_pkg::DIVD_W'(prev_freq_q);
        diff_d  = (freq_q >= prev_freq_q) ? freq_q - prev_freq_q : prev_freq_q - freq_q;
        state_d = ST_TLOAD;
      end
      ST_TLOAD: begin
        // Harmonic term is below 2^22, so the top bits of the numerator are
        // already below the divisor and only 22 steps are needed
        div_d  = sum_q;
        rem_d  = frc_pkg::DIVQ_W'(num[frc_pkg::PROD_W:frc_pkg::FREQ_W]);
        quo_d  = {num[frc_pkg::FREQ_W-1:0], 2'b00};
        iter_d = frc_pkg::ITER_W'(frc_pkg::FREQ_W);
        if (sum_q == '0) begin
          quo_d   = '0;
          state_d = ST_RMUL;
        end else begin
          state_d = ST_TDIV;
        end
      end
      ST_RMUL: begin
        prod_d  = mul_p;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q) begin
          // Finish the compare on the cycle the product lands, then hold
          out_valid_d  = 1'b1;
          out_freq_d   = freq_q;
          out_rate_d   = rate_sat;
          out_now_d    = now;
          out_before_d = prev_unst_q;
          prev_freq_d  = freq_q;
          prev_unst_d  = now;
        end else if (out_o.ready) begin
          out_valid_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      freq_thr_q   <= frc_pkg::FREQ_THR_RESET;
      rate_thr_q   <= frc_pkg::RATE_THR_RESET;
      prev_freq_q  <= frc_pkg::RESET_FREQ;
      prev_unst_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_freq_q   <= '0;
      out_rate_q   <= '0;
      out_now_q    <= 1'b0;
      out_before_q <= 1'b0;
      iter_q       <= '0;
    end else begin
      state_q      <= state_d;
      freq_thr_q   <= freq_thr_d;
      rate_thr_q   <= rate_thr_d;
      prev_freq_q  <= prev_freq_d;
      prev_unst_q  <= prev_unst_d;
      out_valid_q  <= out_valid_d;
      out_freq_q   <= out_freq_d;
      out_rate_q   <= out_rate_d;
      out_now_q    <= out_now_d;
      out_before_q <= out_before_d;
      iter_q       <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q <= freq_d;
    diff_q <= diff_d;
    sum_q  <= sum_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    prod_q <= prod_d;
  end

endmodule

### tb/sv/tb_frequency_rocof_stability_check_unit.sv
module tb_frequency_rocof_stability_check_unit;

  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 2500;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned RUN_PHASES     = 7;
  localparam int unsigned PHASE_ITEMS    = 276;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [frc_pkg::FREQ_W-1:0] frequency;
    logic [frc_pkg::RATE_W-1:0] rate_of_change;
    logic                       unstable_now;
    logic                       unstable_before;
  } stability_result_t;

  class stability_scoreboard;
    logic [frc_pkg::FREQ_W:0]   last_freq;
    logic                       last_unstable;
    logic [frc_pkg::THR_W-1:0]  freq_thr;
    logic [frc_pkg::THR_W-1:0]  rate_thr;
    stability_result_t          awaited[$];
    int unsigned                mismatches;

    function new();
      last_freq     = (frc_pkg::FREQ_W+1)'(frc_pkg::RESET_FREQ);
      last_unstable = 1'b0;
      freq_thr      = frc_pkg::FREQ_THR_RESET;
      rate_thr      = frc_pkg::RATE_THR_RESET;
      mismatches    = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void set_threshold(logic idx, logic [frc_pkg::THR_W-1:0] value);
      if (idx == frc_pkg::REG_FREQ_THR) freq_thr = value;
      else rate_thr = value;
    endfunction

    // Work out frequency and rate for one period count and advance the history
    function void note_count(logic [frc_pkg::COUNT_W-1:0] count);
      longint unsigned   f, p, diff, sum, harm, rate;
      stability_result_t predicted;
      if (count == '0) begin
        f = longint'(frc_pkg::FREQ_MAX);
      end else begin
        f = (longint'(frc_pkg::SAMPLE_RATE_HZ) * 256) / longint'(count);
        if (f > longint'(frc_pkg::FREQ_MAX)) f = longint'(frc_pkg::FREQ_MAX);
      end
      p    = longint'(last_freq);
      diff = (f >= p) ? f - p : p - f;
      sum  = f + p;
      harm = (sum == 0) ? 0 : (2 * f * p) / sum;
      rate = (diff * harm) >> frc_pkg::FRAC_W;
      if (rate > longint'(frc_pkg::RATE_MAX)) rate = longint'(frc_pkg::RATE_MAX);
      predicted.frequency       = frc_pkg::FREQ_W'(f);
      predicted.rate_of_change  = frc_pkg::RATE_W'(rate);
      predicted.unstable_now    = (f < longint'(freq_thr) * 256) ||
                                  (rate > longint'(rate_thr) * 256);
      predicted.unstable_before = last_unstable;
      awaited.push_back(predicted);
      last_freq     = (frc_pkg::FREQ_W+1)'(f);
      last_unstable = predicted.unstable_now;
    endfunction

    function void check_result(stability_result_t got);
      stability_result_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("result with nothing pending: f=%0d r=%0d now=%0b before=%0b",
                       got.frequency, got.rate_of_change, got.unstable_now,
                       got.unstable_before));
        return;
      end
      want = awaited.pop_front();
      if (got.frequency !== want.frequency || got.rate_of_change !== want.rate_of_change ||
          got.unstable_now !== want.unstable_now ||
          got.unstable_before !== want.unstable_before) begin
        flag($sformatf("expected f=%0d r=%0d now=%0b before=%0b, got f=%0d r=%0d now=%0b before=%0b",
                       want.frequency, want.rate_of_change, want.unstable_now,
                       want.unstable_before, got.frequency, got.rate_of_change,
                       got.unstable_now, got.unstable_before));
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [frc_pkg::PADDR_W-1:0]   paddr;
  logic [frc_pkg::PDATA_W-1:0]   pwdata;
  logic [frc_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  frc_in_if  in_if ();
  frc_out_if out_if ();

  frequency_rocof_stability_check_unit dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  stability_scoreboard sb = new();
  stability_result_t   seen;
  bit                  idle_en;
  bit                  hold_req;
  int                  nominal;
  int unsigned         stuck;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) sb.note_count(in_if.period_count);
      if (out_if.valid && out_if.ready) begin
        seen.frequency       = out_if.frequency;
        seen.rate_of_change  = out_if.rate_of_change;
        seen.unstable_now    = out_if.unstable_now;
        seen.unstable_before = out_if.unstable_before;
        sb.check_result(seen);
      end
    end
  end

  // Count cycles without any transaction or register access
  always @(posedge clk) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end else begin
        out_if.ready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [frc_pkg::THR_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = frc_pkg::PADDR_W'({idx, 2'b00});
    pwdata  = frc_pkg::PDATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_threshold(idx, value);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== frc_pkg::PDATA_W'(value))
      sb.flag($sformatf("register %0d read back %0d, expected %0d", idx, prdata, value));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic send_count(input logic [frc_pkg::COUNT_W-1:0] count);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.period_count = count;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (sb.awaited.size() != 0) @(negedge clk);
  endtask

  // Mostly a drifting mains period near 50 Hz, with wide values mixed in
  function automatic logic [frc_pkg::COUNT_W-1:0] next_count();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      if ($urandom_range(0, 15) == 0) nominal = $urandom_range(250, 420);
      else nominal = nominal + int'($urandom_range(0, 6)) - 3;
      if (nominal < 100) nominal = 100;
      if (nominal > 1000) nominal = 1000;
      return frc_pkg::COUNT_W'(nominal);
    end else if (pick <= 7) begin
      return frc_pkg::COUNT_W'($urandom);
    end else if (pick == 8) begin
      return frc_pkg::COUNT_W'($urandom_range(0, 64));
    end
    return frc_pkg::COUNT_W'($urandom_range(1000, 65535));
  endfunction

  initial begin
    logic [frc_pkg::COUNT_W-1:0] directed_counts[];
    logic [frc_pkg::THR_W-1:0]   f_thr;
    logic [frc_pkg::THR_W-1:0]   r_thr;

    directed_counts = '{
      16'd320, 16'd0, 16'd0, 16'd1, 16'd0, 16'd2, 16'd65535, 16'd1, 16'd65535,
      16'hAAAA, 16'h5555, 16'h8000, 16'd321, 16'd320, 16'd319, 16'd327, 16'd80,
      16'd16000, 16'h7FFF, 16'hFFFE, 16'd319, 16'd320};
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.period_count = '0;
    idle_en            = 1'b1;
    hold_req           = 1'b0;
    nominal            = 320;
    repeat (6) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Reset thresholds first, then the extremes of the period count
    foreach (directed_counts[i]) send_count(directed_counts[i]);
    wait_drained();

    for (int ph = 0; ph < RUN_PHASES; ph++) begin
      case (ph)
        0: begin f_thr = '0;        r_thr = '0;        end
        1: begin f_thr = '1;        r_thr = '1;        end
        2: begin f_thr = frc_pkg::THR_W'(49); r_thr = frc_pkg::THR_W'(2);  end
        3: begin f_thr = frc_pkg::THR_W'(50); r_thr = frc_pkg::THR_W'(10); end
        default: begin
          f_thr = frc_pkg::THR_W'($urandom_range(40, 60));
          r_thr = frc_pkg::THR_W'($urandom_range(0, 1023));
        end
      endcase
      if (ph == RUN_PHASES - 1) idle_en = 1'b0;
      write_reg(frc_pkg::REG_FREQ_THR, f_thr);
      write_reg(frc_pkg::REG_RATE_THR, r_thr);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == 40) hold_req = 1'b1;
        if (ph == 3 && i == 100) wait_drained();
        send_count(next_count());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
src/frc_pkg.sv
src/frc_in_if.sv
src/frc_out_if.sv
src/frequency_rocof_stability_check_unit.sv
tb/sv/tb_frequency_rocof_stability_check_unit.sv
